// ===== hdl/segmented_font_header_checker_defines.svh =====
// Assertion macros shared by the font header checker RTL.
// Included by modules that carry concurrent assertions.
`ifndef SEGMENTED_FONT_HEADER_CHECKER_DEFINES_SVH
`define SEGMENTED_FONT_HEADER_CHECKER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SFHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SFHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sfhc_pkg.sv =====
// Package for the segmented font header checker: payload structs,
// status codes, parse phases and segment ids. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfhc_pkg;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  technology;
    logic [15:0] resolution_x;
    logic [15:0] resolution_y;
    logic [63:0] complement_bits;
    logic [23:0] gt_offset;
    logic [23:0] gc_offset;
    logic [23:0] vt_offset;
    logic [2:0]  tables_found;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_BAD     = 4'd1,
    ST_MISSING = 4'd2,
    ST_NULLSZ  = 4'd3,
    ST_FIELDS  = 4'd4,
    ST_BR      = 4'd5,
    ST_GT      = 4'd6,
    ST_GC      = 4'd7,
    ST_VT      = 4'd8,
    ST_UNKNOWN = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    PH_INIT = 3'd0,
    PH_WAIT = 3'd1,
    PH_ID   = 3'd2,
    PH_SIZE = 3'd3,
    PH_DATA = 3'd4,
    PH_STOP = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    K_SKIP = 3'd0,
    K_CC   = 3'd1,
    K_BR   = 3'd2,
    K_GT   = 3'd3,
    K_GC   = 3'd4,
    K_VT   = 3'd5
  } kind_e;

  localparam logic [2:0] REG_TECH_OFS  = 3'd0;
  localparam logic [2:0] REG_SEG_START = 3'd1;
  localparam logic [2:0] REG_HDR_END   = 3'd2;
  localparam logic [2:0] REG_WIDE      = 3'd3;
  localparam logic [2:0] REG_REJECT    = 3'd4;

  localparam logic [7:0]  TECH_BITMAP   = 8'd254;
  localparam logic [7:0]  TECH_TRUETYPE = 8'd1;
  localparam logic [15:0] ID_NULL = 16'hFFFF;
  localparam logic [15:0] ID_VI   = 16'h5649;
  localparam logic [15:0] ID_CC   = 16'h4343;
  localparam logic [15:0] ID_BR   = 16'h4252;
  localparam logic [15:0] ID_GT   = 16'h4754;
  localparam logic [15:0] ID_GC   = 16'h4743;
  localparam logic [15:0] ID_VT   = 16'h5654;
  localparam logic [31:0] GT_MIN_LEN = 32'd92;

endpackage
`default_nettype wire

// ===== hdl/sfhc_regs.sv =====
// APB-style configuration registers of the font header checker.
// Depends on sfhc_pkg for register indexes.
`timescale 1ns / 1ps
`default_nettype none
module sfhc_regs #(
  parameter int OFFSET_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [4:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [OFFSET_BITS-1:0]      tech_ofs_o,
  output logic [OFFSET_BITS-1:0]      seg_start_o,
  output logic [OFFSET_BITS-1:0]      hdr_end_o,
  output logic                        wide_o,
  output logic                        reject_o
);
  logic [OFFSET_BITS-1:0] tech_q, start_q, end_q;
  logic wide_q, reject_q, wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tech_q <= '0; start_q <= '0; end_q <= '0; wide_q <= 1'b0; reject_q <= 1'b0;
    end else if (wr) begin
      case (idx)
        sfhc_pkg::REG_TECH_OFS:  tech_q   <= pwdata[OFFSET_BITS-1:0];
        sfhc_pkg::REG_SEG_START: start_q  <= pwdata[OFFSET_BITS-1:0];
        sfhc_pkg::REG_HDR_END:   end_q    <= pwdata[OFFSET_BITS-1:0];
        sfhc_pkg::REG_WIDE:      wide_q   <= pwdata[0];
        sfhc_pkg::REG_REJECT:    reject_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      sfhc_pkg::REG_TECH_OFS:  prdata[OFFSET_BITS-1:0] = tech_q;
      sfhc_pkg::REG_SEG_START: prdata[OFFSET_BITS-1:0] = start_q;
      sfhc_pkg::REG_HDR_END:   prdata[OFFSET_BITS-1:0] = end_q;
      sfhc_pkg::REG_WIDE:      prdata[0] = wide_q;
      sfhc_pkg::REG_REJECT:    prdata[0] = reject_q;
      default: prdata = '0;
    endcase
  end

  assign tech_ofs_o = tech_q;
  assign seg_start_o = start_q;
  assign hdr_end_o = end_q;
  assign wide_o = wide_q;
  assign reject_o = reject_q;
endmodule
`default_nettype wire

// ===== hdl/segmented_font_header_checker.sv =====
// Segmented font header checker top level: byte parser and result register.
// Depends on sfhc_pkg, sfhc_regs and the assertion macro header.
//
// Usage: font header bytes enter on in_valid_i/in_data_i, offset 0 marked
// by first_byte, which restarts the scan. One transaction is accepted when
// in_valid_i is high and in_stall_o is low. Each byte is parsed in the cycle
// it is accepted; the byte at offset header_end-1 produces one result
// transaction on out_valid_o/out_data_o in the next cycle.
// Throughput is one byte per cycle while in_stall_o stays low; the per-byte
// update of the parser state is the single stage that sets it. Other bytes produce no result.
// A result waiting behind out_stall_i is held in the output register; while
// it waits, the next byte is still taken unless that byte would itself
// produce a result, in which case in_stall_o rises until the output drains.
// Configuration must be written through the APB-style port only while idle; the block does not enforce this.
// Reset clears the configuration registers, the parser state and the
// output valid flag; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "segmented_font_header_checker_defines.svh"
module segmented_font_header_checker #(
  parameter int OFFSET_BITS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sfhc_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sfhc_pkg::out_item_t     out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  localparam int OB = OFFSET_BITS;

  logic [OB-1:0] tech_ofs, seg_start, hdr_end;
  logic wide, reject;

  sfhc_regs #(.OFFSET_BITS(OB)) u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .tech_ofs_o(tech_ofs), .seg_start_o(seg_start), .hdr_end_o(hdr_end),
    .wide_o(wide), .reject_o(reject)
  );

  // Parser state.
  logic [OB-1:0] pos_q, pos_d, org_q, org_d;
  sfhc_pkg::phase_e ph_q, ph_d;
  sfhc_pkg::kind_e kind_q, kind_d;
  logic [15:0] id_q, id_d, scr_q, scr_d, prev_q, prev_d, rx_q, rx_d, ry_q, ry_d;
  logic [31:0] len_q, len_d, cnt_q, cnt_d;
  logic [7:0] tech_q, tech_d;
  logic [3:0] err_q, err_d;
  logic [63:0] cc_q, cc_d;
  logic [OB-1:0] gt_q, gt_d, gc_q, gc_d, vt_q, vt_d;
  logic [2:0] fnd_q, fnd_d;
  logic req_q, req_d, var_q, var_d, nh_q, nh_d, ns_q, ns_d, tail_q, tail_d;

  logic ovalid_q;
  sfhc_pkg::out_item_t odata_q, res;

  logic acc, emit;
  logic [7:0] b;
  logic [2:0] hs;
  logic [OB:0] np;
  logic [OB:0] nextorg;

  assign b = in_data_i.header_byte;
  assign hs = wide ? 3'd6 : 3'd4;

  // Whether the accepted byte would end the header (post-restart position).
  logic [OB-1:0] pos_eff;
  logic fb_clear_init;
  assign pos_eff = in_data_i.first_byte ? '0 : pos_q;
  assign emit = (pos_eff < hdr_end) && ({1'b0, pos_eff} + 1'b1 == {1'b0, hdr_end});
  assign in_stall_o = ovalid_q & out_stall_i & emit;
  assign acc = in_valid_i & ~in_stall_o;
  assign fb_clear_init = 1'b0;

  // Segment walk helper: start a segment header at origin o.
  function automatic void start_at(input logic [OB:0] o, input logic [OB-1:0] he,
                                   input logic [2:0] h, output logic [OB-1:0] org,
                                   output sfhc_pkg::phase_e ph, output logic tl,
                                   output logic set_tl);
    org = o[OB-1:0];
    set_tl = 1'b0;
    tl = 1'b0;
    if ({1'b0, he} >= o && ({1'b0, he} - o) >= {{(OB-2){1'b0}}, h}) begin
      ph = sfhc_pkg::PH_WAIT;
    end else begin
      ph = sfhc_pkg::PH_STOP;
      set_tl = 1'b1;
      tl = (o != {1'b0, he});
    end
  endfunction

  always_comb begin
    logic [OB:0] room;
    logic [33:0] need;
    logic [15:0] w;
    logic fin, ok, fl, stl, tlv;
    logic [OB-1:0] o2;
    sfhc_pkg::phase_e p2;
    pos_d = pos_q; org_d = org_q; ph_d = ph_q; kind_d = kind_q; id_d = id_q;
    scr_d = scr_q; prev_d = prev_q; rx_d = rx_q; ry_d = ry_q; len_d = len_q;
    cnt_d = cnt_q; tech_d = tech_q; err_d = err_q; cc_d = cc_q; gt_d = gt_q;
    gc_d = gc_q; vt_d = vt_q; fnd_d = fnd_q; req_d = req_q; var_d = var_q;
    nh_d = nh_q; ns_d = ns_q; tail_d = tail_q;
    room = '0; need = '0; w = '0; fin = 1'b0; ok = 1'b1; fl = 1'b0;
    stl = 1'b0; tlv = 1'b0; o2 = '0; p2 = sfhc_pkg::PH_STOP;
    np = '0; nextorg = '0;
    if (acc) begin
      if (in_data_i.first_byte) begin
        pos_d = '0; ph_d = sfhc_pkg::PH_INIT; id_d = '0; len_d = '0; cnt_d = '0;
        org_d = '0; tech_d = '0; scr_d = '0; prev_d = '0; err_d = '0; rx_d = '0;
        ry_d = '0; fnd_d = '0; gt_d = '0; gc_d = '0; vt_d = '0; cc_d = '1;
        req_d = 1'b0; var_d = 1'b0; nh_d = 1'b0; ns_d = 1'b0; tail_d = 1'b0;
        kind_d = sfhc_pkg::K_SKIP;
      end
      if (ph_d == sfhc_pkg::PH_INIT) begin
        start_at({1'b0, seg_start}, hdr_end, hs, o2, p2, tlv, stl);
        org_d = o2; ph_d = p2;
        if (stl) tail_d = tlv;
      end
      if (pos_d < hdr_end) begin
        if (pos_d == tech_ofs) tech_d = b;
        if ({1'b0, pos_d} == {1'b0, tech_ofs} + 1'b1 && b != 8'd0) var_d = 1'b1;
        if (hdr_end >= {{(OB-3){1'b0}}, hs}) begin
          np = {1'b0, hdr_end} - {{(OB-2){1'b0}}, hs};
          if ({1'b0, pos_d} == np || {1'b0, pos_d} == np + 1'b1) begin
            if (b != 8'hFF) nh_d = 1'b1;
          end else if ({1'b0, pos_d} >= np + 2'd2 && b != 8'd0) ns_d = 1'b1;
        end
        case (ph_d)
          sfhc_pkg::PH_WAIT: begin
            if (pos_d == org_d) begin
              id_d = {8'd0, b}; cnt_d = 32'd1; ph_d = sfhc_pkg::PH_ID;
            end
          end
          sfhc_pkg::PH_ID: begin
            id_d = {id_d[7:0], b}; len_d = '0; cnt_d = '0; ph_d = sfhc_pkg::PH_SIZE;
          end
          sfhc_pkg::PH_SIZE: begin
            len_d = {len_d[23:0], b};
            cnt_d = cnt_d + 1'b1;
            if (cnt_d == 32'(hs) - 32'd2) begin
              // Segment header complete: classify and check its size.
              room = {1'b0, hdr_end} - {1'b0, org_d};
              need = {2'b0, len_d} + 34'(hs);
              kind_d = sfhc_pkg::K_SKIP;
              if (need > 34'(room)) begin
                fl = 1'b1; w = 16'(sfhc_pkg::ST_BAD); ok = 1'b0;
              end else if (id_d == sfhc_pkg::ID_NULL) begin
                if ({1'b0, org_d} != {1'b0, hdr_end} - (OB+1)'(hs)) begin
                  fl = 1'b1; w = 16'(sfhc_pkg::ST_BAD); ok = 1'b0;
                end
              end else if (id_d == sfhc_pkg::ID_VI) begin
                kind_d = sfhc_pkg::K_SKIP;
              end else if (id_d == sfhc_pkg::ID_CC) begin
                if (len_d != 32'd8) begin
                  fl = 1'b1; w = 16'(sfhc_pkg::ST_BAD); ok = 1'b0;
                end else kind_d = sfhc_pkg::K_CC;
              end else if (tech_d == sfhc_pkg::TECH_BITMAP) begin
                if (id_d == sfhc_pkg::ID_BR) begin
                  if (len_d != 32'd4) begin
                    fl = 1'b1; w = 16'(sfhc_pkg::ST_BR); ok = 1'b0;
                  end else kind_d = sfhc_pkg::K_BR;
                end else if (reject) begin
                  fl = 1'b1; w = 16'(sfhc_pkg::ST_UNKNOWN); ok = 1'b0;
                end
              end else if (id_d == sfhc_pkg::ID_GT) begin
                if (len_d < sfhc_pkg::GT_MIN_LEN) begin
                  fl = 1'b1; w = 16'(sfhc_pkg::ST_GT); ok = 1'b0;
                end else kind_d = sfhc_pkg::K_GT;
              end else if (id_d == sfhc_pkg::ID_GC) begin
                if (len_d < 32'd6) begin
                  fl = 1'b1; w = 16'(sfhc_pkg::ST_GC); ok = 1'b0;
                end else kind_d = sfhc_pkg::K_GC;
              end else if (id_d == sfhc_pkg::ID_VT) begin
                if (len_d[1:0] != 2'd0 || len_d < 32'd4) begin
                  fl = 1'b1; w = 16'(sfhc_pkg::ST_VT); ok = 1'b0;
                end else kind_d = sfhc_pkg::K_VT;
              end else if (reject) begin
                fl = 1'b1; w = 16'(sfhc_pkg::ST_UNKNOWN); ok = 1'b0;
              end
              if (ok) begin
                cnt_d = '0; scr_d = '0; ph_d = sfhc_pkg::PH_DATA;
                if (len_d == 32'd0) fin = 1'b1;
              end
            end
          end
          sfhc_pkg::PH_DATA: begin
            case (kind_d)
              sfhc_pkg::K_CC: cc_d = {cc_d[55:0], b};
              sfhc_pkg::K_BR: begin
                if (cnt_d < 32'd2) rx_d = {rx_d[7:0], b};
                else if (cnt_d < 32'd4) ry_d = {ry_d[7:0], b};
              end
              sfhc_pkg::K_GT: begin
                if (cnt_d < 32'd4) begin
                  if (b != ((cnt_d == 32'd1) ? 8'd1 : 8'd0)) begin
                    fl = 1'b1; w = 16'(sfhc_pkg::ST_GT); ok = 1'b0;
                  end
                end else if (cnt_d == 32'd4) scr_d = {8'd0, b};
                else if (cnt_d == 32'd5 && {scr_d[7:0], b} < 16'd5) begin
                  fl = 1'b1; w = 16'(sfhc_pkg::ST_GT); ok = 1'b0;
                end
              end
              sfhc_pkg::K_GC: begin
                if (cnt_d == 32'd0 || cnt_d == 32'd4) scr_d = {8'd0, b};
                else if (cnt_d == 32'd1 && {scr_d[7:0], b} != 16'd0) begin
                  fl = 1'b1; w = 16'(sfhc_pkg::ST_GC); ok = 1'b0;
                end else if (cnt_d == 32'd5 &&
                             {2'b0, len_d} != 34'({scr_d[7:0], b}) * 34'd6 + 34'd6) begin
                  fl = 1'b1; w = 16'(sfhc_pkg::ST_GC); ok = 1'b0;
                end
              end
              sfhc_pkg::K_VT: begin
                if (cnt_d[1:0] == 2'd0) scr_d = {8'd0, b};
                else if (cnt_d[1:0] == 2'd1) begin
                  if (cnt_d > 32'd1 && prev_d >= {scr_d[7:0], b}) begin
                    fl = 1'b1; w = 16'(sfhc_pkg::ST_VT); ok = 1'b0;
                  end else begin
                    prev_d = {scr_d[7:0], b};
                    if ({1'b0, cnt_d} + 33'd3 == {1'b0, len_d} &&
                        {scr_d[7:0], b} != 16'hFFFF) begin
                      fl = 1'b1; w = 16'(sfhc_pkg::ST_VT); ok = 1'b0;
                    end
                  end
                end
              end
              default: ;
            endcase
            if (ok) begin
              cnt_d = cnt_d + 1'b1;
              if (cnt_d == len_d) fin = 1'b1;
            end
          end
          default: ;
        endcase
        if (fin) begin
          case (kind_d)
            sfhc_pkg::K_BR: begin
              if (rx_d == 16'd0 || ry_d == 16'd0) begin
                fl = 1'b1; w = 16'(sfhc_pkg::ST_BR); fin = 1'b0;
              end else req_d = 1'b1;
            end
            sfhc_pkg::K_GT: begin gt_d = org_d; fnd_d[0] = 1'b1; req_d = 1'b1; end
            sfhc_pkg::K_GC: begin gc_d = org_d; fnd_d[1] = 1'b1; end
            sfhc_pkg::K_VT: begin vt_d = org_d; fnd_d[2] = 1'b1; end
            default: ;
          endcase
          if (fin) begin
            nextorg = {1'b0, org_d} + (OB+1)'(hs) + (OB+1)'(len_d);
            // Sizes past the header end were already rejected, so the origin sum cannot wrap.
            start_at(nextorg, hdr_end, hs, o2, p2, tlv, stl);
            org_d = o2; ph_d = p2;
            if (stl) tail_d = tlv;
          end
        end
        if (fl) begin
          if (err_d == 4'd0) err_d = w[3:0];
          ph_d = sfhc_pkg::PH_STOP;
        end
        pos_d = pos_d + 1'b1;
      end
    end
  end

  // Final status from the updated state.
  always_comb begin
    res = '0;
    if (hdr_end < OB'(hs) || nh_d) res.status = sfhc_pkg::ST_MISSING;
    else if (ns_d) res.status = sfhc_pkg::ST_NULLSZ;
    else if (tech_d != sfhc_pkg::TECH_BITMAP && tech_d != sfhc_pkg::TECH_TRUETYPE)
      res.status = sfhc_pkg::ST_FIELDS;
    else if (var_d) res.status = sfhc_pkg::ST_FIELDS;
    else if (err_d != 4'd0) res.status = err_d;
    else if (!req_d) res.status = sfhc_pkg::ST_MISSING;
    else if (tail_d || ph_d != sfhc_pkg::PH_STOP) res.status = sfhc_pkg::ST_BAD;
    else res.status = sfhc_pkg::ST_OK;
    res.technology = tech_d;
    res.resolution_x = rx_d;
    res.resolution_y = ry_d;
    res.complement_bits = cc_d;
    res.gt_offset = 24'(gt_d);
    res.gc_offset = 24'(gc_d);
    res.vt_offset = 24'(vt_d);
    res.tables_found = fnd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; org_q <= '0; ph_q <= sfhc_pkg::PH_INIT; kind_q <= sfhc_pkg::K_SKIP;
      id_q <= '0; scr_q <= '0; prev_q <= '0; rx_q <= '0; ry_q <= '0; len_q <= '0;
      cnt_q <= '0; tech_q <= '0; err_q <= '0; cc_q <= '1; gt_q <= '0; gc_q <= '0;
      vt_q <= '0; fnd_q <= '0; req_q <= 1'b0; var_q <= 1'b0; nh_q <= 1'b0;
      ns_q <= 1'b0; tail_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      pos_q <= pos_d; org_q <= org_d; ph_q <= ph_d; kind_q <= kind_d; id_q <= id_d;
      scr_q <= scr_d; prev_q <= prev_d; rx_q <= rx_d; ry_q <= ry_d; len_q <= len_d;
      cnt_q <= cnt_d; tech_q <= tech_d; err_q <= err_d; cc_q <= cc_d; gt_q <= gt_d;
      gc_q <= gc_d; vt_q <= vt_d; fnd_q <= fnd_d; req_q <= req_d; var_q <= var_d;
      nh_q <= nh_d; ns_q <= ns_d; tail_q <= tail_d;
      if (acc && emit && !fb_clear_init) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && emit) odata_q <= res;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o = odata_q;

  `SFHC_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, acc && emit, out_valid_o,
                    "accepted last byte did not raise a result")
  `SFHC_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, out_valid_o && out_stall_i && emit,
                   in_stall_o, "pending result could be overwritten")
  `SFHC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_data_o), "stalled result changed")
  `SFHC_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o,
                   out_data_o.status <= 4'd9, "status code out of range")
endmodule
`default_nettype wire

// ===== tb/sv/segmented_font_header_checker_test.sv =====
// Self-checking testbench for the segmented font header checker.
// Depends on sfhc_pkg and the segmented_font_header_checker RTL; drives whole
// headers and checks every result against an in-bench header parser.
`timescale 1ns / 1ps
module segmented_font_header_checker_test;

  localparam int ITEM_GOAL   = 1850;
  localparam int CYCLE_LIMIT = 2000000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  sfhc_pkg::in_item_t    in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  sfhc_pkg::out_item_t   out_data_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [4:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  segmented_font_header_checker u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Register copy held by the parser model.
  int unsigned cfg_tech_ofs, cfg_seg_start, cfg_hdr_end, cfg_wide, cfg_reject;

  // Parser model state.
  int unsigned       pos, seg_id, seg_len, seg_cnt, seg_org, tech, scratch, prev_glyph;
  int unsigned       res_x, res_y, found, tbl_ofs[3];
  sfhc_pkg::status_e first_err;
  sfhc_pkg::phase_e  phase;
  sfhc_pkg::kind_e   kind;
  logic [63:0]       compl_bits;
  bit                req_seen, var_bad, nullhdr_bad, nullsz_bad, tail_left;

  sfhc_pkg::out_item_t want_q[$];
  int                  errors, results_seen, items_sent;
  sfhc_pkg::status_e   last_status;
  bit                  calm;
  int unsigned         cycles;
  byte unsigned        hdr_q[$];

  function automatic int unsigned head_len();
    return cfg_wide ? 6 : 4;
  endfunction

  function automatic void scan_clear();
    pos = 0; phase = sfhc_pkg::PH_INIT; seg_id = 0; seg_len = 0; seg_cnt = 0;
    seg_org = 0; tech = 0; scratch = 0; prev_glyph = 0; first_err = sfhc_pkg::ST_OK;
    res_x = 0; res_y = 0; found = 0; tbl_ofs[0] = 0; tbl_ofs[1] = 0; tbl_ofs[2] = 0;
    compl_bits = '1; req_seen = 0; var_bad = 0; nullhdr_bad = 0; nullsz_bad = 0;
    tail_left = 0; kind = sfhc_pkg::K_SKIP;
  endfunction

  function automatic void scan_fail(sfhc_pkg::status_e code);
    if (first_err == sfhc_pkg::ST_OK) first_err = code;
    phase = sfhc_pkg::PH_STOP;
  endfunction

  function automatic void open_segment(longint unsigned origin);
    longint unsigned hs, he;
    hs = head_len();
    he = cfg_hdr_end;
    seg_org = origin[31:0];
    if (he >= origin && he - origin >= hs) begin
      phase = sfhc_pkg::PH_WAIT;
    end else begin
      phase = sfhc_pkg::PH_STOP;
      tail_left = (origin != he);
    end
  endfunction

  function automatic void close_segment();
    if (kind == sfhc_pkg::K_BR) begin
      if (res_x == 0 || res_y == 0) begin
        scan_fail(sfhc_pkg::ST_BR);
        return;
      end
      req_seen = 1;
    end else if (kind == sfhc_pkg::K_GT) begin
      tbl_ofs[0] = seg_org; found |= 1; req_seen = 1;
    end else if (kind == sfhc_pkg::K_GC) begin
      tbl_ofs[1] = seg_org; found |= 2;
    end else if (kind == sfhc_pkg::K_VT) begin
      tbl_ofs[2] = seg_org; found |= 4;
    end
    open_segment(longint'(seg_org) + head_len() + longint'(seg_len));
  endfunction

  function automatic void classify_segment();
    longint unsigned hs, room, len;
    hs = head_len();
    room = longint'(cfg_hdr_end) - longint'(seg_org);
    len = seg_len;
    if (len + hs > room) begin
      scan_fail(sfhc_pkg::ST_BAD);
      return;
    end
    kind = sfhc_pkg::K_SKIP;
    if (seg_id == sfhc_pkg::ID_NULL) begin
      if (longint'(seg_org) != longint'(cfg_hdr_end) - hs) begin
        scan_fail(sfhc_pkg::ST_BAD);
        return;
      end
    end else if (seg_id == sfhc_pkg::ID_VI) begin
    end else if (seg_id == sfhc_pkg::ID_CC) begin
      if (len != 8) begin
        scan_fail(sfhc_pkg::ST_BAD);
        return;
      end
      kind = sfhc_pkg::K_CC;
    end else if (tech == sfhc_pkg::TECH_BITMAP) begin
      if (seg_id == sfhc_pkg::ID_BR) begin
        if (len != 4) begin
          scan_fail(sfhc_pkg::ST_BR);
          return;
        end
        kind = sfhc_pkg::K_BR;
      end else if (cfg_reject) begin
        scan_fail(sfhc_pkg::ST_UNKNOWN);
        return;
      end
    end else if (seg_id == sfhc_pkg::ID_GT) begin
      if (len < sfhc_pkg::GT_MIN_LEN) begin
        scan_fail(sfhc_pkg::ST_GT);
        return;
      end
      kind = sfhc_pkg::K_GT;
    end else if (seg_id == sfhc_pkg::ID_GC) begin
      if (len < 6) begin
        scan_fail(sfhc_pkg::ST_GC);
        return;
      end
      kind = sfhc_pkg::K_GC;
    end else if (seg_id == sfhc_pkg::ID_VT) begin
      if (len[1:0] != 0 || len < 4) begin
        scan_fail(sfhc_pkg::ST_VT);
        return;
      end
      kind = sfhc_pkg::K_VT;
    end else if (cfg_reject) begin
      scan_fail(sfhc_pkg::ST_UNKNOWN);
      return;
    end
    seg_cnt = 0;
    scratch = 0;
    phase = sfhc_pkg::PH_DATA;
    if (len == 0) close_segment();
  endfunction

  function automatic void consume_data(int unsigned b);
    int unsigned i, w;
    i = seg_cnt;
    w = (scratch << 8) | b;
    case (kind)
      sfhc_pkg::K_CC: compl_bits = {compl_bits[55:0], b[7:0]};
      sfhc_pkg::K_BR: begin
        if (i < 2) res_x = ((res_x << 8) | b) & 16'hFFFF;
        else if (i < 4) res_y = ((res_y << 8) | b) & 16'hFFFF;
      end
      sfhc_pkg::K_GT: begin
        if (i < 4) begin
          if (b != ((i == 1) ? 1 : 0)) begin
            scan_fail(sfhc_pkg::ST_GT);
            return;
          end
        end else if (i == 4) begin
          scratch = b;
        end else if (i == 5 && w < 5) begin
          scan_fail(sfhc_pkg::ST_GT);
          return;
        end
      end
      sfhc_pkg::K_GC: begin
        if (i == 0 || i == 4) begin
          scratch = b;
        end else if (i == 1 && w != 0) begin
          scan_fail(sfhc_pkg::ST_GC);
          return;
        end else if (i == 5 && longint'(seg_len) != longint'(w) * 6 + 6) begin
          scan_fail(sfhc_pkg::ST_GC);
          return;
        end
      end
      sfhc_pkg::K_VT: begin
        if (i[1:0] == 0) begin
          scratch = b;
        end else if (i[1:0] == 1) begin
          w &= 16'hFFFF;
          if (i > 1 && prev_glyph >= w) begin
            scan_fail(sfhc_pkg::ST_VT);
            return;
          end
          prev_glyph = w;
          if (longint'(i) + 3 == longint'(seg_len) && w != 16'hFFFF) begin
            scan_fail(sfhc_pkg::ST_VT);
            return;
          end
        end
      end
      default: ;
    endcase
    seg_cnt = i + 1;
    if (seg_cnt == seg_len) close_segment();
  endfunction

  function automatic sfhc_pkg::status_e compose_status();
    if (cfg_hdr_end < head_len() || nullhdr_bad) return sfhc_pkg::ST_MISSING;
    if (nullsz_bad) return sfhc_pkg::ST_NULLSZ;
    if (tech != sfhc_pkg::TECH_BITMAP && tech != sfhc_pkg::TECH_TRUETYPE)
      return sfhc_pkg::ST_FIELDS;
    if (var_bad) return sfhc_pkg::ST_FIELDS;
    if (first_err != sfhc_pkg::ST_OK) return first_err;
    if (!req_seen) return sfhc_pkg::ST_MISSING;
    if (tail_left || phase != sfhc_pkg::PH_STOP) return sfhc_pkg::ST_BAD;
    return sfhc_pkg::ST_OK;
  endfunction

  // Advances the header parser by one byte; returns 1 when a result is due.
  function automatic bit parse_byte(sfhc_pkg::in_item_t it,
                                    output sfhc_pkg::out_item_t res);
    int unsigned b, p, hs, np;
    b = it.header_byte;
    hs = head_len();
    res = '0;
    if (it.first_byte) scan_clear();
    if (phase == sfhc_pkg::PH_INIT) open_segment(cfg_seg_start);
    if (pos >= cfg_hdr_end) return 0;
    p = pos;
    if (p == cfg_tech_ofs) tech = b;
    if (longint'(p) == longint'(cfg_tech_ofs) + 1 && b != 0) var_bad = 1;
    if (cfg_hdr_end >= hs) begin
      np = cfg_hdr_end - hs;
      if (p == np || p == np + 1) begin
        if (b != 8'hFF) nullhdr_bad = 1;
      end else if (p >= np + 2 && b != 0) begin
        nullsz_bad = 1;
      end
    end
    case (phase)
      sfhc_pkg::PH_WAIT: if (p == seg_org) begin
        seg_id = b; seg_cnt = 1; phase = sfhc_pkg::PH_ID;
      end
      sfhc_pkg::PH_ID: begin
        seg_id = ((seg_id << 8) | b) & 16'hFFFF;
        seg_len = 0; seg_cnt = 0; phase = sfhc_pkg::PH_SIZE;
      end
      sfhc_pkg::PH_SIZE: begin
        seg_len = (seg_len << 8) | b;
        seg_cnt++;
        if (seg_cnt == hs - 2) classify_segment();
      end
      sfhc_pkg::PH_DATA: consume_data(b);
      default: ;
    endcase
    pos = p + 1;
    if (p + 1 != cfg_hdr_end) return 0;
    res.status = compose_status();
    res.technology = tech[7:0];
    res.resolution_x = res_x[15:0];
    res.resolution_y = res_y[15:0];
    res.complement_bits = compl_bits;
    res.gt_offset = tbl_ofs[0][23:0];
    res.gc_offset = tbl_ofs[1][23:0];
    res.vt_offset = tbl_ofs[2][23:0];
    res.tables_found = found[2:0];
    return 1;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("segmented_font_header_checker_test: errors");
      $finish;
    end
  end

  // Scoreboard: results are checked before the byte of the same edge is parsed.
  always @(posedge clk_i) begin
    sfhc_pkg::out_item_t got, want, res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_data_o;
      results_seen++;
      last_status = sfhc_pkg::status_e'(got.status);
      if (want_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = want_q.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        // The collected values only carry meaning for a clean header.
        if (want.status == sfhc_pkg::ST_OK) begin
          if (got.technology != want.technology) begin
            $error("technology: expected %0d, got %0d", want.technology, got.technology);
            errors++;
          end
          if (got.resolution_x != want.resolution_x) begin
            $error("resolution_x: expected %0d, got %0d",
                   want.resolution_x, got.resolution_x);
            errors++;
          end
          if (got.resolution_y != want.resolution_y) begin
            $error("resolution_y: expected %0d, got %0d",
                   want.resolution_y, got.resolution_y);
            errors++;
          end
          if (got.complement_bits != want.complement_bits) begin
            $error("complement_bits: expected %h, got %h",
                   want.complement_bits, got.complement_bits);
            errors++;
          end
          if (got.gt_offset != want.gt_offset) begin
            $error("gt_offset: expected %0d, got %0d", want.gt_offset, got.gt_offset);
            errors++;
          end
          if (got.gc_offset != want.gc_offset) begin
            $error("gc_offset: expected %0d, got %0d", want.gc_offset, got.gc_offset);
            errors++;
          end
          if (got.vt_offset != want.vt_offset) begin
            $error("vt_offset: expected %0d, got %0d", want.vt_offset, got.vt_offset);
            errors++;
          end
          if (got.tables_found != want.tables_found) begin
            $error("tables_found: expected %0d, got %0d",
                   want.tables_found, got.tables_found);
            errors++;
          end
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (parse_byte(in_data_i, res)) want_q.push_back(res);
    end
  end

  // Result-side back-pressure: a fresh stall length after every transaction.
  int unsigned stall_left;
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) stall_left = calm ? 0 : $urandom_range(0, 8);
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // One write with a setup and an access phase, then an idle phase with psel low.
  task automatic reg_write(logic [2:0] idx, int unsigned val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      sfhc_pkg::REG_TECH_OFS:  cfg_tech_ofs = val & 24'hFFFFFF;
      sfhc_pkg::REG_SEG_START: cfg_seg_start = val & 24'hFFFFFF;
      sfhc_pkg::REG_HDR_END:   cfg_hdr_end = val & 24'hFFFFFF;
      sfhc_pkg::REG_WIDE:      cfg_wide = val & 1;
      default:                 cfg_reject = val & 1;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(int unsigned t, int unsigned s, int unsigned e,
                          int unsigned w, int unsigned r);
    reg_write(sfhc_pkg::REG_TECH_OFS, t);
    reg_write(sfhc_pkg::REG_SEG_START, s);
    reg_write(sfhc_pkg::REG_HDR_END, e);
    reg_write(sfhc_pkg::REG_WIDE, w);
    reg_write(sfhc_pkg::REG_REJECT, r);
  endtask

  task automatic send_byte(byte unsigned b, bit first);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{header_byte: b, first_byte: first};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Sends the queued header, then holds off until every result has come.
  task automatic send_header(bit restart);
    foreach (hdr_q[k]) begin
      send_byte(hdr_q[k], restart && k == 0);
      items_sent++;
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic void add_seg(int unsigned id, byte unsigned d[$]);
    int unsigned n;
    n = d.size();
    hdr_q.push_back(id[15:8]);
    hdr_q.push_back(id[7:0]);
    if (cfg_wide) begin
      hdr_q.push_back(n[31:24]);
      hdr_q.push_back(n[23:16]);
    end
    hdr_q.push_back(n[15:8]);
    hdr_q.push_back(n[7:0]);
    foreach (d[k]) hdr_q.push_back(d[k]);
  endfunction

  function automatic void add_body_seg(bit truetype);
    byte unsigned d[$];
    int unsigned n, g, id;
    case ($urandom_range(0, 2))
      0: begin
        n = $urandom_range(0, 5);
        repeat (n) d.push_back($urandom);
        add_seg(sfhc_pkg::ID_VI, d);
      end
      1: begin
        repeat (8) d.push_back($urandom);
        add_seg(sfhc_pkg::ID_CC, d);
      end
      default: begin
        if (truetype && $urandom_range(0, 1)) begin
          n = $urandom_range(0, 2);
          d = '{8'h00, 8'h00, $urandom, $urandom, 8'h00, n[7:0]};
          repeat (n * 6) d.push_back($urandom);
          add_seg(sfhc_pkg::ID_GC, d);
        end else if (truetype) begin
          n = $urandom_range(1, 4);
          g = $urandom_range(0, 100);
          for (int k = 0; k < n; k++) begin
            if (k == n - 1) g = 16'hFFFF;
            d.push_back(g[15:8]);
            d.push_back(g[7:0]);
            d.push_back($urandom);
            d.push_back($urandom);
            g += $urandom_range(1, 1000);
          end
          add_seg(sfhc_pkg::ID_VT, d);
        end else begin
          id = $urandom_range(0, 16'hFFFE);
          n = $urandom_range(0, 3);
          repeat (n) d.push_back($urandom);
          add_seg(id, d);
        end
      end
    endcase
  endfunction

  function automatic void add_required_seg(bit truetype);
    byte unsigned d[$];
    int unsigned v;
    if (truetype) begin
      d = '{8'h00, 8'h01, 8'h00, 8'h00};
      v = $urandom_range(5, 16'hFFFF);
      d.push_back(v[15:8]);
      d.push_back(v[7:0]);
      repeat (86 + $urandom_range(0, 4)) d.push_back($urandom);
      add_seg(sfhc_pkg::ID_GT, d);
    end else begin
      repeat (4) d.push_back($urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 255));
      add_seg(sfhc_pkg::ID_BR, d);
    end
  endfunction

  typedef struct {
    int unsigned       tech_ofs, seg_start, hdr_end, wide, reject;
    int unsigned       len;
    byte unsigned      bytes[16];
    sfhc_pkg::status_e status;
  } row_t;

  row_t rows[5];

  initial begin
    int unsigned t, s, e, w, r, req_at, nseg;
    bit tt;
    byte unsigned tech_b;
    rows[0] = '{0, 2, 14, 0, 0, 14, '{8'hFE, 8'h00, 8'h42, 8'h52, 8'h00, 8'h04, 8'h00,
                8'h64, 8'h00, 8'hC8, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
                sfhc_pkg::ST_OK};
    rows[1] = '{0, 0, 3, 1, 0, 3, '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                sfhc_pkg::ST_MISSING};
    rows[2] = '{0, 2, 10, 0, 1, 10, '{8'hFE, 8'h00, 8'h41, 8'h41, 8'h00, 8'h00, 8'hFF,
                8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                sfhc_pkg::ST_UNKNOWN};
    rows[3] = '{0, 2, 6, 0, 0, 6, '{8'hFE, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                sfhc_pkg::ST_NULLSZ};
    rows[4] = '{0, 2, 6, 0, 0, 6, '{8'h07, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                sfhc_pkg::ST_FIELDS};
    cfg_tech_ofs = 0; cfg_seg_start = 0; cfg_hdr_end = 0; cfg_wide = 0; cfg_reject = 0;
    scan_clear();
    calm = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      set_regs(rows[i].tech_ofs, rows[i].seg_start, rows[i].hdr_end,
               rows[i].wide, rows[i].reject);
      hdr_q.delete();
      for (int k = 0; k < rows[i].len; k++) hdr_q.push_back(rows[i].bytes[k]);
      send_header(1'b1);
      if (last_status != rows[i].status) begin
        $error("status: expected %0d, got %0d", rows[i].status, last_status);
        errors++;
      end
    end

    // Extreme register settings: no result is due for these short headers.
    for (int x = 0; x < 4; x++) begin
      calm = x[0];
      set_regs(24'hFFFFFF, x < 2 ? 24'hFFFFFF : 0, x[0] ? 24'hFFFFFF : 0, 1, 1);
      hdr_q.delete();
      repeat (10) hdr_q.push_back($urandom);
      send_header(1'b1);
    end

    while (items_sent < ITEM_GOAL) begin
      calm = ($urandom_range(0, 4) == 0);
      w = $urandom_range(0, 1);
      r = $urandom_range(0, 1);
      tt = ($urandom_range(0, 2) == 0);
      tech_b = tt ? sfhc_pkg::TECH_TRUETYPE : sfhc_pkg::TECH_BITMAP;
      if ($urandom_range(0, 15) == 0) tech_b = $urandom;
      t = $urandom_range(0, 3);
      s = t + 2 + $urandom_range(0, 2);
      cfg_wide = w;
      hdr_q.delete();
      repeat (s) hdr_q.push_back($urandom);
      hdr_q[t] = tech_b;
      hdr_q[t + 1] = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : 0;
      nseg = $urandom_range(0, 3);
      req_at = $urandom_range(0, nseg);
      for (int k = 0; k <= nseg; k++) begin
        if (k == req_at && $urandom_range(0, 15) != 0) add_required_seg(tt);
        if (k < nseg) add_body_seg(tt);
      end
      hdr_q.push_back(8'hFF);
      hdr_q.push_back(8'hFF);
      repeat (w ? 4 : 2) hdr_q.push_back(8'h00);
      e = hdr_q.size();
      if ($urandom_range(0, 9) == 0) t = s + $urandom_range(0, 6);
      if (t + 1 < e) hdr_q[t] = tech_b;
      if ($urandom_range(0, 4) == 0) hdr_q[$urandom_range(0, e - 1)] = $urandom;
      if ($urandom_range(0, 19) == 0) e = e - $urandom_range(1, 3);
      else if ($urandom_range(0, 19) == 0) e = e + $urandom_range(1, 3);
      set_regs(t, s, e, w, r);
      send_header($urandom_range(0, 24) != 0);
    end

    while (want_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("segmented_font_header_checker_test: clean");
    end else begin
      $display("segmented_font_header_checker_test: errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/sfhc_pkg.sv
hdl/sfhc_regs.sv
hdl/segmented_font_header_checker.sv
tb/sv/segmented_font_header_checker_test.sv
